// File: rtl/dtcq_pkg.sv
// Package for the drum trigger channel qualifier: constants, register codes, packing helpers.
`timescale 1ns / 1ps
`default_nettype none

package dtcq_pkg;

  // Channel count limits
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int CH_W             = 4;

  // Configuration port shape
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_HOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_HOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_CH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SW_CH = 3'd6;

  // Register reset values
  localparam logic [7:0]  CHANGE_THR_RST  = 8'd10;
  localparam logic [7:0]  HIT_THR_RST     = 8'd10;
  localparam logic [15:0] PEDAL_HOLD_RST  = 16'h01FF;
  localparam logic [15:0] STRIKE_HOLD_RST = 16'h0040;
  localparam logic [15:0] SWITCH_HOLD_RST = 16'h0020;
  localparam logic [3:0]  PEDAL_CH_RST    = 4'd2;
  localparam logic [4:0]  FIRST_SW_CH_RST = 5'd12;

  // Packet constants
  localparam logic [1:0] START_BITS  = 2'b11;
  localparam logic [1:0] PARITY_SEED = 2'b11;
  localparam logic [7:0] VEL_CLOSED  = 8'hFF;
  localparam logic [7:0] VEL_OPEN    = 8'h00;

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  // Build the header byte: start bits, channel, 2-bit XOR parity
  function automatic logic [7:0] header_of(input logic [3:0] ch, input logic [7:0] vel);
    logic [1:0] par;
    par = PARITY_SEED ^ ch[3:2] ^ ch[1:0] ^ vel[7:6] ^ vel[5:4] ^ vel[3:2] ^ vel[1:0];
    return {START_BITS, ch, par};
  endfunction

endpackage

`default_nettype wire

// File: rtl/drum_trigger_channel_qualifier_top.sv
// Top level of the drum trigger channel qualifier: per-channel hold and report logic.
//
//  Channel  | Dir | Handshake               | Payload (lowest bit first)
//  ---------+-----+-------------------------+--------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | channel_index[3:0] sample[11:4] pin_level[12]
//  m_axis   | out | m_axis_tvalid/tready    | out_channel[3:0] header_byte[11:4]
//           |     |                         | out_velocity[19:12]
//  cfg      | in  | cfg_we_i                | cfg_idx_i selects register, cfg_data_i value
//
// One visit is accepted per cycle unless a reporting visit stalls; its report passes through the
// input register, then the result register. The per-channel hold and last-value
// registers are read and written in the same cycle, so back-to-back visits to one channel
// see fresh state. Reset clears all hold counters and last values and loads the register
// defaults. A full result register stalls only a visit that reports; quiet visits pass through.
`timescale 1ns / 1ps
`default_nettype none

module drum_trigger_channel_qualifier_top #(
  parameter int NUM_CHANNELS = dtcq_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [dtcq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dtcq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Visit requests
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel_index[3:0], sample[11:4], pin_level[12], zero[15:13]
  input  wire logic [dtcq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Report requests
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_channel[3:0], header_byte[11:4], out_velocity[19:12], zero[23:20]
  output logic [dtcq_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers
  logic [7:0]  change_thr_q, hit_thr_q;
  logic [15:0] pedal_hold_q, strike_hold_q, switch_hold_q;
  logic [3:0]  pedal_ch_q;
  logic [4:0]  first_sw_ch_q;

  // Capture register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_thr_q  <= dtcq_pkg::CHANGE_THR_RST;
      hit_thr_q     <= dtcq_pkg::HIT_THR_RST;
      pedal_hold_q  <= dtcq_pkg::PEDAL_HOLD_RST;
      strike_hold_q <= dtcq_pkg::STRIKE_HOLD_RST;
      switch_hold_q <= dtcq_pkg::SWITCH_HOLD_RST;
      pedal_ch_q    <= dtcq_pkg::PEDAL_CH_RST;
      first_sw_ch_q <= dtcq_pkg::FIRST_SW_CH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtcq_pkg::CFG_CHANGE_THR:  change_thr_q  <= cfg_data_i[7:0];
        dtcq_pkg::CFG_HIT_THR:     hit_thr_q     <= cfg_data_i[7:0];
        dtcq_pkg::CFG_PEDAL_HOLD:  pedal_hold_q  <= cfg_data_i;
        dtcq_pkg::CFG_STRIKE_HOLD: strike_hold_q <= cfg_data_i;
        dtcq_pkg::CFG_SWITCH_HOLD: switch_hold_q <= cfg_data_i;
        dtcq_pkg::CFG_PEDAL_CH:    pedal_ch_q    <= cfg_data_i[3:0];
        dtcq_pkg::CFG_FIRST_SW_CH: first_sw_ch_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic       in_valid_q;
  logic [3:0] in_ch_q;
  logic [7:0] in_smp_q;
  logic       in_lvl_q;

  // Result register
  logic       out_valid_q;
  logic [3:0] out_ch_q;
  logic [7:0] out_hdr_q, out_vel_q;

  // Per-channel state
  logic [15:0] hold_q [NUM_CHANNELS];
  logic [7:0]  last_q [NUM_CHANNELS];

  logic            ch_ok;
  logic [IdxW-1:0] idx;
  logic [15:0]     hold_cur, hold_d;
  logic [7:0]      last_cur, last_d;
  logic [7:0]      diff, vel;
  logic            is_pedal, is_strike, report, advance;

  assign idx      = in_ch_q[IdxW-1:0];
  assign ch_ok    = ({1'b0, in_ch_q} < 5'(NUM_CHANNELS));
  assign hold_cur = hold_q[idx];
  assign last_cur = last_q[idx];
  assign diff     = (last_cur > in_smp_q) ? (last_cur - in_smp_q) : (in_smp_q - last_cur);
  assign is_pedal  = (in_ch_q == pedal_ch_q);
  assign is_strike = !is_pedal && ({1'b0, in_ch_q} < first_sw_ch_q);

  // Decide report, velocity and state updates for the held visit
  always_comb begin
    report = 1'b0;
    vel    = in_smp_q;
    hold_d = hold_cur;
    last_d = last_cur;
    if (hold_cur != 16'd0) begin
      hold_d = hold_cur - 16'd1;
    end else if (is_pedal) begin
      if (diff > change_thr_q) begin
        report = 1'b1;
        hold_d = pedal_hold_q;
        last_d = in_smp_q;
      end
    end else if (is_strike) begin
      if (in_smp_q > hit_thr_q) begin
        report = 1'b1;
        hold_d = strike_hold_q;
      end
    end else if (last_cur != {7'd0, in_lvl_q}) begin
      report = 1'b1;
      hold_d = switch_hold_q;
      last_d = {7'd0, in_lvl_q};
      vel    = in_lvl_q ? dtcq_pkg::VEL_OPEN : dtcq_pkg::VEL_CLOSED;
    end
  end

  // A reporting visit waits for room in the result register
  assign advance       = in_valid_q && (!(ch_ok && report) || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Hold the visit until it can advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q  <= s_axis_tdata[3:0];
      in_smp_q <= s_axis_tdata[11:4];
      in_lvl_q <= s_axis_tdata[12];
    end
  end

  // Update the visited channel's counters; out-of-range channels leave state alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hold_q[i] <= 16'd0;
        last_q[i] <= 8'd0;
      end
    end else if (advance && ch_ok) begin
      hold_q[idx] <= hold_d;
      last_q[idx] <= last_d;
    end
  end

  // Load a report or drain the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && ch_ok && report) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ch_ok && report) begin
      out_ch_q  <= in_ch_q;
      out_hdr_q <= dtcq_pkg::header_of(in_ch_q, vel);
      out_vel_q <= vel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_vel_q, out_hdr_q, out_ch_q};

  // A blocked visit stays in the input register unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_ch_q) && $stable(in_smp_q)
      && $stable(in_lvl_q))
    else $error("stalled visit lost or changed");

  // A pending report is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_hdr_q)
      && $stable(out_vel_q) && $stable(out_ch_q))
    else $error("pending report overwritten");

  // Every report carries its start bits and its own channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_hdr_q[7:6] == dtcq_pkg::START_BITS && out_hdr_q[5:2] == out_ch_q)
    else $error("malformed header");

  // A report comes only from a channel whose hold counter is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ch_ok && report |-> hold_cur == 16'd0)
    else $error("report from a held channel");

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the drum trigger channel qualifier top level.
`timescale 1ns / 1ps

module tb;

  localparam logic [dtcq_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;   // unmapped register index
  localparam int QUIET_LIMIT  = 5000;
  localparam int LONG_STALL   = 300;
  localparam int SETTLE_TICKS = 8;

  typedef struct packed {
    logic [3:0] ch;
    logic [7:0] smp;
    logic       pin;
  } visit_t;

  typedef struct packed {
    logic [3:0] ch;
    logic [7:0] hdr;
    logic [7:0] vel;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dtcq_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [dtcq_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [dtcq_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [dtcq_pkg::M_TDATA_W-1:0] m_axis_tdata;

  // Predictor state and register copy
  logic [15:0] hold_cnt [16];
  logic [7:0]  last_val [16];
  logic [7:0]  change_thr, hit_thr;
  logic [15:0] pedal_hold, strike_hold, switch_hold;
  logic [3:0]  pedal_ch;
  logic [4:0]  first_sw;

  visit_t  visit_q[$];
  report_t report_q[$];

  int unsigned visits_done = 0;
  int unsigned reports_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned errors = 0;
  int unsigned quiet = 0;
  int unsigned stall_tickets = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;
  logic visit_fire = 1'b0;

  drum_trigger_channel_qualifier_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Fold the channel and velocity into a 2-bit parity, seeded with ones
  function automatic logic [1:0] packet_parity(input logic [3:0] ch, input logic [7:0] vel);
    logic [11:0] bits;
    logic [1:0]  p;
    bits = {ch, vel};
    p = 2'b11;
    for (int i = 0; i < 6; i++) p = p ^ bits[2*i +: 2];
    return p;
  endfunction

  // Advance the channel state for one visit and queue the report it causes
  task automatic qualify_visit(input visit_t v);
    report_t    r;
    logic [7:0] diff;
    logic [7:0] vel;
    logic       fires;
    fires = 1'b0;
    vel = '0;
    if (hold_cnt[v.ch] != 16'd0) begin
      hold_cnt[v.ch] = hold_cnt[v.ch] - 16'd1;
    end else if (v.ch == pedal_ch) begin
      diff = (last_val[v.ch] > v.smp) ? last_val[v.ch] - v.smp : v.smp - last_val[v.ch];
      if (diff > change_thr) begin
        hold_cnt[v.ch] = pedal_hold;
        last_val[v.ch] = v.smp;
        vel = v.smp;
        fires = 1'b1;
      end
    end else if ({1'b0, v.ch} < first_sw) begin
      if (v.smp > hit_thr) begin
        hold_cnt[v.ch] = strike_hold;
        vel = v.smp;
        fires = 1'b1;
      end
    end else if (last_val[v.ch] != {7'd0, v.pin}) begin
      hold_cnt[v.ch] = switch_hold;
      last_val[v.ch] = {7'd0, v.pin};
      vel = v.pin ? dtcq_pkg::VEL_OPEN : dtcq_pkg::VEL_CLOSED;
      fires = 1'b1;
    end
    if (fires) begin
      r.ch  = v.ch;
      r.hdr = {2'b11, v.ch, packet_parity(v.ch, vel)};
      r.vel = vel;
      report_q.push_back(r);
    end
  endtask

  // Drive one register write and mirror it in the predictor
  task automatic write_reg(input logic [dtcq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dtcq_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      dtcq_pkg::CFG_CHANGE_THR:  change_thr  = val[7:0];
      dtcq_pkg::CFG_HIT_THR:     hit_thr     = val[7:0];
      dtcq_pkg::CFG_PEDAL_HOLD:  pedal_hold  = val;
      dtcq_pkg::CFG_STRIKE_HOLD: strike_hold = val;
      dtcq_pkg::CFG_SWITCH_HOLD: switch_hold = val;
      dtcq_pkg::CFG_PEDAL_CH:    pedal_ch    = val[3:0];
      dtcq_pkg::CFG_FIRST_SW_CH: first_sw    = val[4:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic push_visit(input logic [3:0] ch, input logic [7:0] smp, input logic pin);
    visit_t v;
    v.ch  = ch;
    v.smp = smp;
    v.pin = pin;
    visit_q.push_back(v);
  endtask

  // Hold off until every visit is taken and every report is back, then let the pipe empty
  task automatic settle();
    while (visit_q.size() != 0 || s_axis_tvalid || report_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_thr();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd255;
      default: return 16'($urandom_range(60));
    endcase
  endfunction

  function automatic logic [15:0] pick_hold();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'($urandom_range(6, 40));
      default: return 16'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [15:0] pick_first_sw();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd16;
      default: return 16'($urandom_range(16));
    endcase
  endfunction

  task automatic shuffle_regs();
    write_reg(dtcq_pkg::CFG_CHANGE_THR, pick_thr());
    write_reg(dtcq_pkg::CFG_HIT_THR, pick_thr());
    write_reg(dtcq_pkg::CFG_PEDAL_HOLD, pick_hold());
    write_reg(dtcq_pkg::CFG_STRIKE_HOLD, pick_hold());
    write_reg(dtcq_pkg::CFG_SWITCH_HOLD, pick_hold());
    write_reg(dtcq_pkg::CFG_PEDAL_CH, 16'($urandom_range(15)));
    write_reg(dtcq_pkg::CFG_FIRST_SW_CH, pick_first_sw());
  endtask

  // Bias samples toward zero, full scale and the two thresholds
  function automatic visit_t rand_visit();
    visit_t v;
    v.ch = ($urandom_range(3) == 0) ? pedal_ch : 4'($urandom_range(15));
    case ($urandom_range(5))
      0: v.smp = 8'h00;
      1: v.smp = 8'hFF;
      2: v.smp = hit_thr + 8'($urandom_range(2)) - 8'd1;
      3: v.smp = last_val[v.ch] + change_thr + 8'($urandom_range(1));
      default: v.smp = 8'($urandom_range(255));
    endcase
    v.pin = 1'($urandom_range(1));
    return v;
  endfunction

  function automatic int unsigned src_idle_pct();
    if (visits_done < 370) return 36;
    if (visits_done < 740) return 54;
    return 0;
  endfunction

  function automatic int unsigned sink_idle_pct();
    if (visits_done < 370) return 54;
    if (visits_done < 740) return 36;
    return 0;
  endfunction

  // Visit driver: hold a pending request until taken, otherwise offer the next one
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || visit_fire) begin
      if (visit_q.size() != 0 && $urandom_range(99) >= src_idle_pct()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, visit_q[0].pin, visit_q[0].smp, visit_q[0].ch};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Report sink: random back-pressure plus long hold-offs on request
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_tickets != stall_seen) begin
      m_axis_tready <= 1'b0;
      stall_seen <= stall_tickets;
      stall_left <= LONG_STALL;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct());
    end
  end

  // Monitor: predict on each accepted visit, compare each accepted report
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    visit_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        qualify_visit(visit_q.pop_front());
        visits_done++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ch  = m_axis_tdata[3:0];
        got.hdr = m_axis_tdata[11:4];
        got.vel = m_axis_tdata[19:12];
        reports_seen++;
        if (report_q.size() == 0) begin
          $display("%0t unexpected report: ch %h hdr %h vel %h", $time, got.ch, got.hdr,
                   got.vel);
          errors++;
        end else begin
          want = report_q.pop_front();
          if (got.ch != want.ch || got.hdr != want.hdr || got.vel != want.vel) begin
            $display("%0t report mismatch: expected ch %h hdr %h vel %h, got ch %h hdr %h vel %h",
                     $time, want.ch, want.hdr, want.vel, got.ch, got.hdr, got.vel);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    visit_t v;
    change_thr  = dtcq_pkg::CHANGE_THR_RST;
    hit_thr     = dtcq_pkg::HIT_THR_RST;
    pedal_hold  = dtcq_pkg::PEDAL_HOLD_RST;
    strike_hold = dtcq_pkg::STRIKE_HOLD_RST;
    switch_hold = dtcq_pkg::SWITCH_HOLD_RST;
    pedal_ch    = dtcq_pkg::PEDAL_CH_RST;
    first_sw    = dtcq_pkg::FIRST_SW_CH_RST;
    for (int i = 0; i < 16; i++) begin
      hold_cnt[i] = '0;
      last_val[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: strike, hold, pedal change, switch close and open
    push_visit(4'd0, 8'hFF, 1'b0);
    push_visit(4'd0, 8'hFF, 1'b0);
    push_visit(4'd2, 8'd11, 1'b1);
    push_visit(4'd2, 8'd0, 1'b1);
    push_visit(4'd5, 8'd10, 1'b0);
    push_visit(4'd6, 8'd11, 1'b0);
    push_visit(4'd12, 8'd0, 1'b0);
    push_visit(4'd15, 8'd0, 1'b1);
    push_visit(4'd14, 8'd0, 1'b0);
    settle();

    // Zero thresholds and holds, pedal inside the switch range, unmapped write
    write_reg(dtcq_pkg::CFG_CHANGE_THR, 16'd0);
    write_reg(dtcq_pkg::CFG_HIT_THR, 16'd0);
    write_reg(dtcq_pkg::CFG_PEDAL_HOLD, 16'd0);
    write_reg(dtcq_pkg::CFG_STRIKE_HOLD, 16'd0);
    write_reg(dtcq_pkg::CFG_SWITCH_HOLD, 16'd0);
    write_reg(dtcq_pkg::CFG_PEDAL_CH, 16'd13);
    write_reg(dtcq_pkg::CFG_FIRST_SW_CH, 16'd12);
    write_reg(CFG_NO_REG, 16'hFFFF);
    push_visit(4'd13, 8'd0, 1'b1);
    push_visit(4'd13, 8'hFF, 1'b0);
    push_visit(4'd13, 8'hFF, 1'b1);
    push_visit(4'd1, 8'd0, 1'b0);
    push_visit(4'd1, 8'd1, 1'b0);
    push_visit(4'd1, 8'd1, 1'b1);
    push_visit(4'd11, 8'd128, 1'b0);
    settle();

    // Full-scale thresholds and no switch channels at all
    write_reg(dtcq_pkg::CFG_CHANGE_THR, 16'd255);
    write_reg(dtcq_pkg::CFG_HIT_THR, 16'd255);
    write_reg(dtcq_pkg::CFG_PEDAL_CH, 16'd0);
    write_reg(dtcq_pkg::CFG_FIRST_SW_CH, 16'd16);
    push_visit(4'd15, 8'hFF, 1'b0);
    push_visit(4'd0, 8'd0, 1'b1);
    push_visit(4'd14, 8'd200, 1'b0);
    settle();

    // Burst of strikes with zero hold while the sink holds off
    write_reg(dtcq_pkg::CFG_HIT_THR, 16'd0);
    write_reg(dtcq_pkg::CFG_STRIKE_HOLD, 16'd0);
    write_reg(dtcq_pkg::CFG_PEDAL_CH, 16'd15);
    stall_tickets++;
    for (int i = 0; i < 110; i++) begin
      push_visit(4'($urandom_range(14)), 8'($urandom_range(1, 255)), 1'($urandom_range(1)));
    end
    settle();

    // Random settings, random visits
    for (int ph = 0; ph < 9; ph++) begin
      shuffle_regs();
      for (int i = 0; i < 110; i++) begin
        v = rand_visit();
        visit_q.push_back(v);
      end
      settle();
    end

    // Largest holds, every channel but the pedal a switch
    write_reg(dtcq_pkg::CFG_PEDAL_HOLD, 16'hFFFF);
    write_reg(dtcq_pkg::CFG_STRIKE_HOLD, 16'hFFFF);
    write_reg(dtcq_pkg::CFG_SWITCH_HOLD, 16'hFFFF);
    write_reg(dtcq_pkg::CFG_CHANGE_THR, 16'd0);
    write_reg(dtcq_pkg::CFG_PEDAL_CH, 16'd3);
    write_reg(dtcq_pkg::CFG_FIRST_SW_CH, 16'd0);
    push_visit(4'd4, 8'd200, 1'b0);
    push_visit(4'd4, 8'd200, 1'b1);
    push_visit(4'd10, 8'd0, 1'b1);
    push_visit(4'd10, 8'd0, 1'b0);
    push_visit(4'd3, 8'hFF, 1'b0);
    push_visit(4'd3, 8'd0, 1'b1);
    settle();

    repeat (10) @(posedge clk_i);
    if (report_q.size() != 0) begin
      $display("%0t %0d expected reports never arrived", $time, report_q.size());
      errors += report_q.size();
    end
    $display("Run covered %0d visits and %0d reports over %0d register writes.",
             visits_done, reports_seen, reg_writes);
    $display("Mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: drum_trigger_channel_qualifier_top.f
rtl/dtcq_pkg.sv
rtl/drum_trigger_channel_qualifier_top.sv
test/tb.sv
